/* hdl/rca_pkg.sv */
// Shared types and constants for the relay controller with auto-off.
// No dependencies; imported by every module of the block.
`default_nettype none

package rca_pkg;

   localparam int ACTION_WIDTH = 3;
   localparam int BUTTON_WIDTH = 3;
   localparam int INDEX_WIDTH  = 2;
   localparam int CMD_WIDTH    = 2;
   localparam int STATES_WIDTH = 3;
   localparam int SECS_WIDTH   = 16;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [SECS_WIDTH-1:0] AUTO_OFF_RESET     = 16'd3600;
   localparam logic [SECS_WIDTH-1:0] PING_TIMEOUT_RESET = 16'd60;

   typedef enum logic [ACTION_WIDTH-1:0] {
      ACT_SAMPLE    = 3'd0,
      ACT_COMMAND   = 3'd1,
      ACT_STATUS    = 3'd2,
      ACT_PING      = 3'd3,
      ACT_LINK_LOST = 3'd4,
      ACT_SECOND    = 3'd5
   } action_type;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_NONE   = 2'd0,
      CMD_ON     = 2'd1,
      CMD_OFF    = 2'd2,
      CMD_TOGGLE = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_AUTO_OFF     = 1'b0,
      CSR_PING_TIMEOUT = 1'b1
   } csr_index_type;

   // Item context shared by all relay cells
   typedef struct packed {
      action_type            action;
      logic                  remote;
      logic [SECS_WIDTH-1:0] auto_off_secs;
      cmd_type               command;
   } relay_ctl_type;

   // Per-relay result of one item
   typedef struct packed {
      logic on;
      logic report;
   } relay_stat_type;

endpackage

`default_nettype wire

/* hdl/rca_relay.sv */
// One relay cell: drive state, pending command, button history, auto-off countdown.
// Depends on rca_pkg.
`default_nettype none

module rca_relay
   import rca_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           enable,
   input  relay_ctl_type  ctl,
   input  logic           button_level,
   input  logic           cmd_hit,
   output relay_stat_type stat
);

   logic                  button_ff, button_in;
   logic                  on_ff, on_in;
   cmd_type               pend_cmd_ff, pend_cmd_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [SECS_WIDTH-1:0] count_ff, count_in;
   logic                  armed_ff, armed_in;
   logic [SECS_WIDTH-1:0] count_dec;
   logic                  report;

   assign count_dec = (count_ff != '0) ? count_ff - 1'b1 : count_ff;

   always_comb begin
      button_in     = button_ff;
      on_in         = on_ff;
      pend_cmd_in   = pend_cmd_ff;
      pend_valid_in = pend_valid_ff;
      count_in      = count_ff;
      armed_in      = armed_ff;
      report        = 1'b0;
      unique case (ctl.action)
         ACT_SAMPLE: begin
            button_in = button_level;
            // released -> pushed queues a toggle
            if (button_ff && !button_level) begin
               pend_cmd_in   = CMD_TOGGLE;
               pend_valid_in = 1'b1;
            end
            if (pend_valid_in) begin
               pend_valid_in = 1'b0;
               if (pend_cmd_in != CMD_NONE) begin
                  unique case (pend_cmd_in)
                     CMD_ON:  on_in = 1'b1;
                     CMD_OFF: on_in = 1'b0;
                     default: on_in = !on_ff;
                  endcase
                  report = 1'b1;
                  if (on_in && !ctl.remote && (ctl.auto_off_secs != '0)) begin
                     count_in = ctl.auto_off_secs;
                     armed_in = 1'b1;
                  end
               end
            end
         end
         ACT_COMMAND: begin
            if (cmd_hit) begin
               pend_cmd_in   = ctl.command;
               pend_valid_in = (ctl.command != CMD_NONE);
            end
         end
         ACT_SECOND: begin
            if (armed_ff) begin
               count_in = count_dec;
               if (count_dec == '0) begin
                  armed_in = 1'b0;
                  if (!ctl.remote) begin
                     pend_cmd_in   = CMD_OFF;
                     pend_valid_in = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         button_ff     <= 1'b1;
         on_ff         <= 1'b0;
         pend_cmd_ff   <= CMD_NONE;
         pend_valid_ff <= 1'b0;
         count_ff      <= '0;
         armed_ff      <= 1'b0;
      end else if (enable) begin
         button_ff     <= button_in;
         on_ff         <= on_in;
         pend_cmd_ff   <= pend_cmd_in;
         pend_valid_ff <= pend_valid_in;
         count_ff      <= count_in;
         armed_ff      <= armed_in;
      end
   end

   assign stat.on     = on_in;
   assign stat.report = report;

endmodule

`default_nettype wire

/* hdl/rca_link.sv */
// External control link: remote-active flag and ping age watchdog.
// Depends on rca_pkg.
`default_nettype none

module rca_link
   import rca_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  action_type            action,
   input  logic [SECS_WIDTH-1:0] ping_timeout,
   output logic                  remote,
   output logic                  remote_next
);

   logic                  remote_ff, remote_in;
   logic [SECS_WIDTH-1:0] age_ff, age_in;

   always_comb begin
      remote_in = remote_ff;
      age_in    = age_ff;
      unique case (action)
         ACT_PING: begin
            remote_in = 1'b1;
            age_in    = '0;
         end
         ACT_LINK_LOST: begin
            remote_in = 1'b0;
         end
         ACT_SECOND: begin
            // saturating age, checked after the increment
            age_in = (age_ff != '1) ? age_ff + 1'b1 : age_ff;
            if (remote_ff && (age_in > ping_timeout)) begin
               remote_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remote_ff <= 1'b0;
         age_ff    <= '0;
      end else if (enable) begin
         remote_ff <= remote_in;
         age_ff    <= age_in;
      end
   end

   assign remote      = remote_ff;
   assign remote_next = remote_in;

endmodule

`default_nettype wire

/* hdl/relay_controller_auto_off.sv */
// Top level of the relay controller with auto-off.
// Depends on rca_pkg, rca_relay and rca_link.
`default_nettype none

// Relay controller: RELAY_COUNT relays, each with a button, one pending
// command and an auto-off countdown, plus an external-control link with a
// ping watchdog. Every request transaction (sample tick, relay command,
// status request, ping, link lost, second tick) yields exactly one response
// transaction carrying the relay levels, the report mask and the flags.
// Throughput is one transaction per clock while no response is stalled.
// A request waits in the request register; then the per-relay update and
// the link update fold into the response register in a single pass.
// The request side keeps taking transactions while a response waits, and
// stalls only when both registers are full and the response is stalled.
// Relay commands are only queued; they take effect on the next sample tick.
// csr_* writes (index 0 auto_off_secs, index 1 ping_timeout_secs) must only
// happen with the block idle.
module relay_controller_auto_off
   import rca_pkg::*;
#(
   parameter int RELAY_COUNT = 3
) (
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [SECS_WIDTH-1:0]      csr_data,

   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [ACTION_WIDTH-1:0]    req_action,
   input  logic [BUTTON_WIDTH-1:0]    req_button_levels,
   input  logic [INDEX_WIDTH-1:0]     req_relay_index,
   input  logic [CMD_WIDTH-1:0]       req_relay_command,

   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STATES_WIDTH-1:0]    rsp_relay_states,
   output logic [STATES_WIDTH-1:0]    rsp_report_mask,
   output logic                       rsp_pong_flag,
   output logic                       rsp_device_info_flag,
   output logic                       rsp_external_control
);

   // --- configuration registers ---
   logic [SECS_WIDTH-1:0] auto_off_secs_ff;
   logic [SECS_WIDTH-1:0] ping_timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_off_secs_ff <= AUTO_OFF_RESET;
         ping_timeout_ff  <= PING_TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_AUTO_OFF:     auto_off_secs_ff <= csr_data;
            CSR_PING_TIMEOUT: ping_timeout_ff  <= csr_data;
         endcase
      end
   end

   // --- handshake: request register feeds response register ---
   logic req_valid_ff, req_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;
   logic advance;

   assign advance      = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = req_valid_ff && !advance;
   assign accept       = req_valid && !req_stall;
   assign req_valid_in = accept || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request payload, loaded on accept
   action_type              req_action_ff;
   logic [BUTTON_WIDTH-1:0] req_button_levels_ff;
   logic [INDEX_WIDTH-1:0]  req_relay_index_ff;
   cmd_type                 req_relay_command_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         req_action_ff        <= action_type'(req_action);
         req_button_levels_ff <= req_button_levels;
         req_relay_index_ff   <= req_relay_index;
         req_relay_command_ff <= cmd_type'(req_relay_command);
      end
   end

   // --- external control link ---
   logic remote;
   logic remote_next;

   rca_link u_link (
      .clock        (clock),
      .reset        (reset),
      .enable       (advance),
      .action       (req_action_ff),
      .ping_timeout (ping_timeout_ff),
      .remote       (remote),
      .remote_next  (remote_next)
   );

   // --- relay cells; expiry and arming see the link state before this item ---
   relay_ctl_type  ctl;
   relay_stat_type stat [RELAY_COUNT];

   assign ctl.action        = req_action_ff;
   assign ctl.remote        = remote;
   assign ctl.auto_off_secs = auto_off_secs_ff;
   assign ctl.command       = req_relay_command_ff;

   for (genvar i = 0; i < RELAY_COUNT; i++) begin : g_relay
      logic button_level;
      logic cmd_hit;

      // relays without a button bit see a released button
      if (i < BUTTON_WIDTH) begin : g_btn
         assign button_level = req_button_levels_ff[i];
      end else begin : g_nobtn
         assign button_level = 1'b1;
      end

      assign cmd_hit = (int'(req_relay_index_ff) == i);

      rca_relay u_relay (
         .clock        (clock),
         .reset        (reset),
         .enable       (advance),
         .ctl          (ctl),
         .button_level (button_level),
         .cmd_hit      (cmd_hit),
         .stat         (stat[i])
      );
   end

   // --- response assembly ---
   logic [STATES_WIDTH-1:0] states_in;
   logic [STATES_WIDTH-1:0] report_in;
   logic                    is_ping;

   assign is_ping = (req_action_ff == ACT_PING);

   for (genvar b = 0; b < STATES_WIDTH; b++) begin : g_bit
      if (b < RELAY_COUNT) begin : g_used
         assign states_in[b] = stat[b].on;
         assign report_in[b] = stat[b].report || is_ping;
      end else begin : g_unused
         assign states_in[b] = 1'b0;
         assign report_in[b] = 1'b0;
      end
   end

   logic [STATES_WIDTH-1:0] rsp_relay_states_ff;
   logic [STATES_WIDTH-1:0] rsp_report_mask_ff;
   logic                    rsp_pong_flag_ff;
   logic                    rsp_device_info_flag_ff;
   logic                    rsp_external_control_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_relay_states_ff     <= states_in;
         rsp_report_mask_ff      <= report_in;
         rsp_pong_flag_ff        <= is_ping;
         rsp_device_info_flag_ff <= (req_action_ff == ACT_STATUS);
         rsp_external_control_ff <= remote_next;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_relay_states     = rsp_relay_states_ff;
   assign rsp_report_mask      = rsp_report_mask_ff;
   assign rsp_pong_flag        = rsp_pong_flag_ff;
   assign rsp_device_info_flag = rsp_device_info_flag_ff;
   assign rsp_external_control = rsp_external_control_ff;

endmodule

`default_nettype wire

/* hdl/rca_checker.sv */
// Port-level checks for the relay controller, bound to the top level.
// Depends on rca_pkg and relay_controller_auto_off.
`default_nettype none

module rca_checker
   import rca_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [STATES_WIDTH-1:0] rsp_relay_states,
   input logic [STATES_WIDTH-1:0] rsp_report_mask,
   input logic                    rsp_pong_flag,
   input logic                    rsp_device_info_flag,
   input logic                    rsp_external_control
);

   // a stalled response transaction stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_relay_states)
         && $stable(rsp_report_mask) && $stable(rsp_pong_flag)
         && $stable(rsp_device_info_flag) && $stable(rsp_external_control))
      else $error("response changed while stalled");

   // an answered ping leaves external control on
   a_pong_remote: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pong_flag |-> rsp_external_control)
      else $error("pong without external control");

   // one action per transaction
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_pong_flag && rsp_device_info_flag))
      else $error("pong and device info together");

   // a status request reports no relay
   a_info_no_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_device_info_flag |-> (rsp_report_mask == '0))
      else $error("status request with report mask");

endmodule

bind relay_controller_auto_off rca_checker u_rca_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_relay_states     (rsp_relay_states),
   .rsp_report_mask      (rsp_report_mask),
   .rsp_pong_flag        (rsp_pong_flag),
   .rsp_device_info_flag (rsp_device_info_flag),
   .rsp_external_control (rsp_external_control)
);

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for relay_controller_auto_off: directed corners, a max
// countdown run and random traffic, checked against a transaction-level predictor.
// Depends on rca_pkg and the relay_controller_auto_off RTL.

module tb;
   import rca_pkg::*;

   localparam int RELAYS          = 3;
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int DRAIN_CYCLES    = 6;      // slack after the last expected response
   localparam int RANDOM_ITEMS    = 370;    // per random phase, four phases
   localparam int COUNTDOWN_TICKS = 8;      // second ticks on the max countdown
   localparam int REPORT_LIMIT    = 100;    // mismatch lines printed before going quiet
   localparam int IDLE_PERCENT    = 34;

   // Actions the block decodes as no-ops
   localparam logic [ACTION_WIDTH-1:0] ACT_SPARE_A = 3'd6;
   localparam logic [ACTION_WIDTH-1:0] ACT_SPARE_B = 3'd7;
   localparam logic [INDEX_WIDTH-1:0]  NO_RELAY    = INDEX_WIDTH'(RELAYS);

   typedef struct packed {
      logic [ACTION_WIDTH-1:0] action;
      logic [BUTTON_WIDTH-1:0] buttons;
      logic [INDEX_WIDTH-1:0]  index;
      logic [CMD_WIDTH-1:0]    cmd;
   } request_type;

   typedef struct packed {
      logic [STATES_WIDTH-1:0] relay_states;
      logic [STATES_WIDTH-1:0] report_mask;
      logic                    pong;
      logic                    device_info;
      logic                    ext_control;
   } response_type;

   // Relay controller predictor plus the queue of responses it still owes
   class relay_scoreboard;
      logic [SECS_WIDTH-1:0] auto_off_secs;
      logic [SECS_WIDTH-1:0] ping_timeout_secs;
      logic                  button_level [RELAYS];
      logic                  relay_on     [RELAYS];
      cmd_type               pend_cmd     [RELAYS];
      logic                  pend_valid   [RELAYS];
      logic [SECS_WIDTH-1:0] countdown    [RELAYS];
      logic                  armed        [RELAYS];
      logic                  remote;
      logic [SECS_WIDTH-1:0] ping_age;
      response_type          expected_q [$];
      int                    errors;

      function new();
         auto_off_secs     = AUTO_OFF_RESET;
         ping_timeout_secs = PING_TIMEOUT_RESET;
         for (int i = 0; i < RELAYS; i++) begin
            button_level[i] = 1'b1;
            relay_on[i]     = 1'b0;
            pend_cmd[i]     = CMD_NONE;
            pend_valid[i]   = 1'b0;
            countdown[i]    = '0;
            armed[i]        = 1'b0;
         end
         remote   = 1'b0;
         ping_age = '0;
         errors   = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [SECS_WIDTH-1:0] value);
         case (idx)
            CSR_AUTO_OFF:     auto_off_secs = value;
            CSR_PING_TIMEOUT: ping_timeout_secs = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Apply every queued command; returns the relays touched
      function logic [STATES_WIDTH-1:0] apply_pending();
         logic [STATES_WIDTH-1:0] mask;
         mask = '0;
         for (int i = 0; i < RELAYS; i++) begin
            if (!pend_valid[i]) continue;
            pend_valid[i] = 1'b0;
            if (pend_cmd[i] == CMD_NONE) continue;
            case (pend_cmd[i])
               CMD_ON:  relay_on[i] = 1'b1;
               CMD_OFF: relay_on[i] = 1'b0;
               default: relay_on[i] = !relay_on[i];
            endcase
            mask[i] = 1'b1;
            if (relay_on[i] && !remote && auto_off_secs != 0) begin
               countdown[i] = auto_off_secs;
               armed[i]     = 1'b1;
            end
         end
         return mask;
      endfunction

      function void note_request(request_type r);
         response_type want;
         want = '0;
         case (r.action)
            ACT_SAMPLE: begin
               for (int i = 0; i < RELAYS; i++) begin
                  if (r.buttons[i] != button_level[i] && !r.buttons[i]) begin
                     pend_cmd[i]   = CMD_TOGGLE;
                     pend_valid[i] = 1'b1;
                  end
                  button_level[i] = r.buttons[i];
               end
               want.report_mask = apply_pending();
            end
            ACT_COMMAND: begin
               if (r.index < RELAYS) begin
                  pend_cmd[r.index]   = cmd_type'(r.cmd);
                  pend_valid[r.index] = (r.cmd != CMD_NONE);
               end
            end
            ACT_STATUS: want.device_info = 1'b1;
            ACT_PING: begin
               remote           = 1'b1;
               ping_age         = '0;
               want.pong        = 1'b1;
               want.report_mask = '1;
            end
            ACT_LINK_LOST: remote = 1'b0;
            ACT_SECOND: begin
               for (int i = 0; i < RELAYS; i++) begin
                  if (!armed[i]) continue;
                  if (countdown[i] != 0) countdown[i]--;
                  if (countdown[i] == 0) begin
                     armed[i] = 1'b0;
                     if (!remote) begin
                        pend_cmd[i]   = CMD_OFF;
                        pend_valid[i] = 1'b1;
                     end
                  end
               end
               if (ping_age != '1) ping_age++;
               if (remote && ping_age > ping_timeout_secs) remote = 1'b0;
            end
            default: ;
         endcase
         for (int i = 0; i < RELAYS; i++) want.relay_states[i] = relay_on[i];
         want.ext_control = remote;
         expected_q.push_back(want);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_response(response_type got);
         response_type want;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: response with none expected, expected nothing, actual %h",
                        $time, got);
            return;
         end
         want = expected_q.pop_front();
         compare_field("relay_states", want.relay_states, got.relay_states);
         compare_field("report_mask", want.report_mask, got.report_mask);
         compare_field("pong_flag", want.pong, got.pong);
         compare_field("device_info_flag", want.device_info, got.device_info);
         compare_field("external_control", want.ext_control, got.ext_control);
      endfunction
   endclass

   // Every DUT input starts at a known value
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_wr_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [SECS_WIDTH-1:0]      csr_data = '0;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [ACTION_WIDTH-1:0]    req_action = '0;
   logic [BUTTON_WIDTH-1:0]    req_button_levels = '1;
   logic [INDEX_WIDTH-1:0]     req_relay_index = '0;
   logic [CMD_WIDTH-1:0]       req_relay_command = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [STATES_WIDTH-1:0]    rsp_relay_states;
   logic [STATES_WIDTH-1:0]    rsp_report_mask;
   logic                       rsp_pong_flag;
   logic                       rsp_device_info_flag;
   logic                       rsp_external_control;

   logic         no_gaps = 1'b0;  // set for one phase: no idling on either side
   int unsigned  cycle_count = 0;
   response_type observed;

   relay_scoreboard sb = new();

   always #5 clock = ~clock;

   relay_controller_auto_off #(
      .RELAY_COUNT(RELAYS)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_action           (req_action),
      .req_button_levels    (req_button_levels),
      .req_relay_index      (req_relay_index),
      .req_relay_command    (req_relay_command),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_relay_states     (rsp_relay_states),
      .rsp_report_mask      (rsp_report_mask),
      .rsp_pong_flag        (rsp_pong_flag),
      .rsp_device_info_flag (rsp_device_info_flag),
      .rsp_external_control (rsp_external_control)
   );

   assign observed = {rsp_relay_states, rsp_report_mask, rsp_pong_flag,
                      rsp_device_info_flag, rsp_external_control};

   // Response side: random backpressure, dropped during the no-gap phase
   always @(posedge clock) begin
      rsp_stall <= !reset && !no_gaps && ($urandom_range(99) < IDLE_PERCENT);
   end

   // A response transaction completes on valid and not stall at the edge.
   // All TB drives are nonblocking, so these reads see pre-edge values.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(observed);
   end

   // Hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Random request: every action including the two spare codes; fields the
   // action ignores carry random junk too. Index 3 (no such relay) now and then.
   function automatic request_type random_request();
      request_type r;
      int unsigned pick;
      r.buttons = BUTTON_WIDTH'($urandom_range(7));
      r.index   = ($urandom_range(9) == 0) ? NO_RELAY : INDEX_WIDTH'($urandom_range(RELAYS - 1));
      r.cmd     = CMD_WIDTH'($urandom_range(3));
      pick      = $urandom_range(99);
      if (pick < 28)      r.action = ACT_SAMPLE;
      else if (pick < 55) r.action = ACT_COMMAND;
      else if (pick < 80) r.action = ACT_SECOND;
      else if (pick < 87) r.action = ACT_PING;
      else if (pick < 92) r.action = ACT_LINK_LOST;
      else if (pick < 97) r.action = ACT_STATUS;
      else                r.action = $urandom_range(1) ? ACT_SPARE_A : ACT_SPARE_B;
      return r;
   endfunction

   // Drive one request transaction; returns at the edge where it is taken.
   // Valid stays high into the next call unless that call idles first.
   task automatic send_request(request_type r);
      if (!no_gaps) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid         <= 1'b1;
      req_action        <= r.action;
      req_button_levels <= r.buttons;
      req_relay_index   <= r.index;
      req_relay_command <= r.cmd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(r);
   endtask

   task automatic send_sample(logic [BUTTON_WIDTH-1:0] buttons);
      request_type r;
      r         = random_request();
      r.action  = ACT_SAMPLE;
      r.buttons = buttons;
      send_request(r);
   endtask

   task automatic send_command(logic [INDEX_WIDTH-1:0] index, cmd_type cmd);
      request_type r;
      r        = random_request();
      r.action = ACT_COMMAND;
      r.index  = index;
      r.cmd    = cmd;
      send_request(r);
   endtask

   task automatic send_event(logic [ACTION_WIDTH-1:0] action);
      request_type r;
      r        = random_request();
      r.action = action;
      send_request(r);
   endtask

   // Stop sending and wait for the block to go quiet
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write both registers; only called with the block drained
   task automatic configure(logic [SECS_WIDTH-1:0] auto_off, logic [SECS_WIDTH-1:0] timeout);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_AUTO_OFF;
      csr_data  <= auto_off;
      @(posedge clock);
      sb.set_register(CSR_AUTO_OFF, auto_off);
      csr_index <= CSR_PING_TIMEOUT;
      csr_data  <= timeout;
      @(posedge clock);
      sb.set_register(CSR_PING_TIMEOUT, timeout);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset register values
      send_event(ACT_STATUS);
      send_event(ACT_SPARE_A);
      send_event(ACT_SPARE_B);
      send_sample(3'b111);
      send_command(2'd0, CMD_ON);
      send_command(2'd1, CMD_TOGGLE);
      send_command(2'd2, CMD_OFF);          // off on a relay already off still reports
      send_command(NO_RELAY, CMD_ON);       // out of range, dropped
      send_sample(3'b111);
      send_command(2'd2, CMD_TOGGLE);
      send_command(2'd2, CMD_NONE);         // cancels the toggle
      send_sample(3'b111);
      send_sample(3'b000);                  // all buttons pushed at once
      send_sample(3'b000);                  // held, no new edge
      send_sample(3'b111);
      send_sample(3'b110);
      send_event(ACT_PING);
      send_command(2'd1, CMD_ON);           // switched on under remote control, not armed
      send_sample(3'b111);
      send_event(ACT_SECOND);
      send_event(ACT_LINK_LOST);
      send_event(ACT_STATUS);

      // Watchdog at the reset timeout: drops on the tick past the limit
      send_event(ACT_PING);
      repeat (int'(PING_TIMEOUT_RESET) + 1) send_event(ACT_SECOND);

      // Auto-off corners with a short countdown
      drain();
      configure(16'd2, 16'd1);
      send_command(2'd0, CMD_ON);
      send_sample(3'b111);
      send_event(ACT_SECOND);
      send_command(2'd0, CMD_ON);           // repeated on re-arms
      send_sample(3'b111);
      send_event(ACT_SECOND);
      send_command(2'd0, CMD_OFF);          // off leaves the countdown armed
      send_sample(3'b111);
      send_event(ACT_SECOND);               // expiry queues an off
      send_sample(3'b111);                  // off applied to a relay already off
      send_command(2'd1, CMD_ON);
      send_sample(3'b111);
      send_event(ACT_PING);
      send_event(ACT_SECOND);
      send_event(ACT_SECOND);               // expiry under remote, then watchdog drop
      send_sample(3'b111);

      // Max countdown and the widest watchdog limit
      drain();
      configure('1, '1);
      send_command(2'd2, CMD_ON);
      send_sample(3'b111);
      send_event(ACT_PING);
      repeat (COUNTDOWN_TICKS) send_event(ACT_SECOND);
      send_event(ACT_STATUS);

      // Random traffic under several register settings
      for (int phase = 0; phase < 4; phase++) begin
         drain();
         case (phase)
            0:       configure(16'd0, 16'd1);
            1:       configure(16'd1, 16'd3);
            2:       configure(16'd5, '1);
            default: configure(SECS_WIDTH'($urandom_range(12, 1)),
                               SECS_WIDTH'($urandom_range(20, 1)));
         endcase
         no_gaps <= (phase == 1);
         repeat (RANDOM_ITEMS) send_request(random_request());
      end

      drain();
      if (sb.errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
